// File: hw/rtl/gbpv_pkg.sv
// Shared types and constants for the planar glyph blitter.
package gbpv_pkg;

   // Operation codes carried in the request's operation field.
   localparam logic OP_DRAW = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   // Printable character range held in the font store.
   localparam logic [7:0] FIRST_CODE = 8'h20;
   localparam logic [7:0] FINAL_CODE = 8'h7F;

   // Font store geometry: 96 glyphs of 8 rows.
   localparam logic [9:0] FONT_DEPTH = 10'd768;
   localparam int FONT_ADDR_W = 10;
   localparam logic [2:0] LAST_ROW = 3'd7;

   // Command queue between the front and back parts.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   // Request transaction payload.
   typedef struct packed {
      logic       operation;
      logic [9:0] pos_x;
      logic [9:0] pos_y;
      logic [7:0] char_code;
      logic [3:0] colour;
      logic [9:0] font_index;
      logic [7:0] font_bits;
   } req_type;

   // Response transaction payload: one merged byte write.
   typedef struct packed {
      logic [15:0] plane_addr;
      logic [7:0]  pixel_mask;
      logic [3:0]  plane_values;
      logic        last;
   } rsp_type;

   // Classified command passed from the front to the back.
   typedef struct packed {
      logic                   is_load;
      logic [FONT_ADDR_W-1:0] font_addr;
      logic [7:0]             font_data;
      logic [6:0]             glyph;
      logic [2:0]             shift;
      logic [7:0]             col_mask0;
      logic [7:0]             col_mask1;
      logic [10:0]            pos_y;
      logic [15:0]            offset;
      logic [3:0]             colour;
   } entry_type;

endpackage

// File: hw/rtl/gbpv_front.sv
// Front part: accepts requests, drops ones with no effect and precomputes draw geometry.
module gbpv_front
   import gbpv_pkg::*;
#(
   parameter int SCREEN_WIDTH = 640
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_stall,
   input  req_type   req_data,
   input  logic      q_full,
   output logic      q_push,
   output entry_type q_entry
);

   localparam logic [10:0] WIDTH_LIM = 11'(SCREEN_WIDTH);
   localparam logic [7:0]  ROW_BYTES = 8'((SCREEN_WIDTH + 7) / 8);

   logic        keep;
   logic [7:0]  bcol0;
   logic [7:0]  bcol1;
   logic [7:0]  col_mask0;
   logic [7:0]  col_mask1;
   logic [17:0] row_base;

   // Loads beyond the store and draws of unprintable codes are dropped here.
   always_comb begin
      case (req_data.operation)
         OP_LOAD: keep = req_data.font_index < FONT_DEPTH;
         OP_DRAW: keep = req_data.char_code inside {[FIRST_CODE:FINAL_CODE]};
         default: keep = 1'b0;
      endcase
   end

   // Byte columns covered by the glyph cell and the pixels left of the right edge.
   assign bcol0 = {1'b0, req_data.pos_x[9:3]};
   assign bcol1 = bcol0 + 8'd1;

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         col_mask0[7-k] = {bcol0, 3'(k)} < WIDTH_LIM;
         col_mask1[7-k] = {bcol1, 3'(k)} < WIDTH_LIM;
      end
   end

   // Byte offset of the first byte of the top glyph row.
   assign row_base = 18'(req_data.pos_y) * 18'(ROW_BYTES);

   always_comb begin
      q_entry           = '0;
      q_entry.is_load   = req_data.operation == OP_LOAD;
      q_entry.font_addr = req_data.font_index;
      q_entry.font_data = req_data.font_bits;
      q_entry.glyph     = 7'(req_data.char_code - FIRST_CODE);
      q_entry.shift     = req_data.pos_x[2:0];
      q_entry.col_mask0 = col_mask0;
      q_entry.col_mask1 = col_mask1;
      q_entry.pos_y     = {1'b0, req_data.pos_y};
      q_entry.offset    = row_base[15:0] + 16'(bcol0);
      q_entry.colour    = req_data.colour;
   end

   // A transaction is taken whenever the queue has room.
   assign req_stall = q_full;
   assign q_push    = req_valid && keep && !q_full;

   // Every pushed command was accepted from the request channel.
   a_push_accepted: assert property (@(posedge clock) disable iff (reset)
      q_push |-> req_valid && !req_stall)
      else $error("front pushed a command without accepting a transaction");

   a_load_in_range: assert property (@(posedge clock) disable iff (reset)
      q_push && q_entry.is_load |-> q_entry.font_addr < FONT_DEPTH)
      else $error("front pushed a load beyond the font store");

   a_draw_code_ok: assert property (@(posedge clock) disable iff (reset)
      q_push && !q_entry.is_load |-> q_entry.glyph <= 7'd95)
      else $error("front pushed a draw of an unprintable code");

endmodule

// File: hw/rtl/gbpv_queue.sv
// Command queue that decouples the front part from the back part.
module gbpv_queue
   import gbpv_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      empty,
   output entry_type head
);

   entry_type              slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff;
   logic [QUEUE_PTR_W:0]   count_in;

   assign full  = count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign head  = slot_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + (QUEUE_PTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QUEUE_PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue pushed while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("queue popped while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QUEUE_PTR_W+1)'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

endmodule

// File: hw/rtl/gbpv_back.sv
// Back part: font store, glyph row sequencer and merged byte-write output.
module gbpv_back
   import gbpv_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 640,
   parameter int SCREEN_HEIGHT = 480
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      q_empty,
   input  entry_type q_head,
   output logic      q_pop,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output rsp_type   rsp_data
);

   localparam logic [15:0] ROW_STEP   = 16'((SCREEN_WIDTH + 7) / 8);
   localparam logic [10:0] HEIGHT_LIM = 11'(SCREEN_HEIGHT);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_ROW   = 3'b010,
      ST_HALF1 = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   logic [7:0]             font_mem [FONT_DEPTH];
   logic [FONT_ADDR_W-1:0] rd_addr_ff;
   logic [FONT_ADDR_W-1:0] rd_addr_in;
   logic [7:0]             rd_data_ff;

   logic [2:0]  row_ff;
   logic [2:0]  row_in;
   logic [10:0] ypos_ff;
   logic [10:0] ypos_in;
   logic [15:0] offset_ff;
   logic [15:0] offset_in;
   logic [2:0]  shift_ff;
   logic [2:0]  shift_in;
   logic [7:0]  colmask0_ff;
   logic [7:0]  colmask0_in;
   logic [7:0]  colmask1_ff;
   logic [7:0]  colmask1_in;
   logic [3:0]  colour_ff;
   logic [3:0]  colour_in;
   logic [7:0]  mask1_ff;
   logic [7:0]  mask1_in;

   rsp_type hold_ff;
   rsp_type hold_in;
   logic    hold_valid_ff;
   logic    hold_valid_in;
   rsp_type rsp_ff;
   rsp_type rsp_in;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;

   logic        rsp_free;
   logic        hold_free;
   logic        hold_move;
   logic [15:0] span;
   logic [7:0]  row_mask0;
   logic [7:0]  row_mask1;
   logic        row_ok;
   logic        row_done;
   logic        finish;
   logic        emit;
   logic [7:0]  emit_mask;
   logic [15:0] emit_offset;
   logic        mem_we;

   // Output staging: the hold slot keeps one write back until it is known whether it is last.
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign hold_free = !hold_valid_ff || rsp_free;

   // Glyph row placed at the pixel offset, split over two bytes and clipped.
   assign span      = {rd_data_ff, 8'h00} >> shift_ff;
   assign row_mask0 = span[15:8] & colmask0_ff;
   assign row_mask1 = span[7:0] & colmask1_ff;
   assign row_ok    = ypos_ff < HEIGHT_LIM;

   // Row sequencer.
   always_comb begin
      state_in    = state_ff;
      rd_addr_in  = rd_addr_ff;
      row_in      = row_ff;
      ypos_in     = ypos_ff;
      offset_in   = offset_ff;
      shift_in    = shift_ff;
      colmask0_in = colmask0_ff;
      colmask1_in = colmask1_ff;
      colour_in   = colour_ff;
      mask1_in    = mask1_ff;
      q_pop       = 1'b0;
      mem_we      = 1'b0;
      emit        = 1'b0;
      emit_mask   = row_mask0;
      emit_offset = offset_ff;
      row_done    = 1'b0;
      finish      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               if (q_head.is_load) begin
                  mem_we = 1'b1;
               end else begin
                  rd_addr_in  = {q_head.glyph, 3'b000};
                  row_in      = '0;
                  ypos_in     = q_head.pos_y;
                  offset_in   = q_head.offset;
                  shift_in    = q_head.shift;
                  colmask0_in = q_head.col_mask0;
                  colmask1_in = q_head.col_mask1;
                  colour_in   = q_head.colour;
                  state_in    = ST_ROW;
               end
            end
         end
         ST_ROW: begin
            if (hold_free) begin
               mask1_in = row_mask1;
               if (row_ok && row_mask0 != 8'h00) begin
                  emit = 1'b1;
               end
               if (row_ok && row_mask1 != 8'h00) begin
                  state_in = ST_HALF1;
               end else begin
                  row_done = 1'b1;
               end
            end
         end
         ST_HALF1: begin
            if (hold_free) begin
               emit        = 1'b1;
               emit_mask   = mask1_ff;
               emit_offset = offset_ff + 16'd1;
               row_done    = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (row_done) begin
         if (row_ff == LAST_ROW) begin
            finish   = 1'b1;
            state_in = ST_IDLE;
         end else begin
            row_in     = row_ff + 3'd1;
            ypos_in    = ypos_ff + 11'd1;
            offset_in  = offset_ff + ROW_STEP;
            rd_addr_in = rd_addr_ff + FONT_ADDR_W'(1);
            state_in   = ST_ROW;
         end
      end
   end

   // Hold slot and response register.
   assign hold_move = hold_valid_ff && (emit || hold_ff.last) && rsp_free;

   always_comb begin
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (emit) begin
         hold_valid_in        = 1'b1;
         hold_in.plane_addr   = emit_offset;
         hold_in.pixel_mask   = emit_mask;
         hold_in.plane_values = colour_ff;
         hold_in.last         = finish;
      end else if (hold_move) begin
         hold_valid_in = 1'b0;
      end else if (finish && hold_valid_ff) begin
         hold_in.last = 1'b1;
      end
      if (hold_move) begin
         rsp_in       = hold_ff;
         rsp_valid_in = 1'b1;
      end else if (rsp_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff  <= rd_addr_in;
      row_ff      <= row_in;
      ypos_ff     <= ypos_in;
      offset_ff   <= offset_in;
      shift_ff    <= shift_in;
      colmask0_ff <= colmask0_in;
      colmask1_ff <= colmask1_in;
      colour_ff   <= colour_in;
      mask1_ff    <= mask1_in;
      hold_ff     <= hold_in;
      rsp_ff      <= rsp_in;
   end

   // Font store: one write port for loads, one registered read port for the sequencer.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         font_mem[q_head.font_addr] <= q_head.font_data;
      end
      rd_data_ff <= font_mem[rd_addr_in];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Between glyphs, any write still held back must already be marked last.
   a_idle_hold_last: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !hold_valid_ff || hold_ff.last)
      else $error("unfinished write held while sequencer idle");

   a_hold_mask: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> hold_ff.pixel_mask != 8'h00)
      else $error("empty byte mask staged for output");

   a_half1_mask: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_HALF1 |-> mask1_ff != 8'h00)
      else $error("second byte visited with an empty mask");

   a_row_start: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE && state_in == ST_ROW |=> row_ff == 3'd0)
      else $error("glyph walk did not start at the top row");

endmodule

// File: hw/rtl/glyph_blit_planar_vga.sv
// Planar glyph blitter: draws 8x8 font glyphs as merged byte writes to a 4-plane frame buffer.
// A load transaction stores one font row. A draw transaction leaves the command queue and
// then walks the glyph rows, with a visit to a second byte for each visible row whose pixels
// reach into it; the row sequencer reads the font store once per row and hands out byte writes,
// waiting while the hold slot is full and the output is stalled.
// Draws of codes outside 0x20..0x7F and loads beyond the store are dropped without a write.
// Because the final write of a glyph is marked with last, each write is held back: it moves to
// the response register as the sequencer produces the following write, or is marked last when
// the sequencer finishes the glyph and then moves on. A four-entry command queue lets new
// transactions be taken while a draw is in progress. The font store has no reset: every glyph
// row must be loaded before it is drawn.
module glyph_blit_planar_vga
   import gbpv_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 640,
   parameter int SCREEN_HEIGHT = 480
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic      q_full;
   logic      q_empty;
   logic      q_push;
   logic      q_pop;
   entry_type q_entry;
   entry_type q_head;

   // Request classification.
   gbpv_front #(
      .SCREEN_WIDTH (SCREEN_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (q_entry)
   );

   // Command queue.
   gbpv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .empty      (q_empty),
      .head       (q_head)
   );

   // Font store and glyph walk.
   gbpv_back #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: sim/glyph_blit_planar_vga_tb.sv
// Self-checking testbench for the planar glyph blitter, with its own write predictor.
`timescale 1ns / 1ps

module glyph_blit_planar_vga_tb
   import gbpv_pkg::*;
;

   localparam int SCREEN_W    = 640;
   localparam int SCREEN_H    = 480;
   localparam int ROW_BYTES   = (SCREEN_W + 7) / 8;
   localparam int GLYPHS      = 96;
   localparam int RANDOM_ITEMS = 370;
   localparam int CALM_AFTER  = 310;
   localparam int DRAIN_CYCLES = 40;
   localparam int QUIET_LIMIT = 2000;

   // One row of the directed table; typed rows carry their expected write by hand.
   typedef struct {
      req_type item;
      bit      typed;
      bit      has_write;
      rsp_type write;
   } directed_step_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // Predictor state: the font store and which rows have been written.
   logic [7:0] font_rows [FONT_DEPTH];
   bit         row_loaded [FONT_DEPTH];
   bit         glyph_ready [GLYPHS];
   int         ready_glyphs [$];

   rsp_type           expected_writes [$];
   directed_step_type steps [$];
   int                mismatch_count = 0;
   int                quiet_cycles = 0;
   int                counted_items = 0;
   bit                calm = 1'b0;

   glyph_blit_planar_vga #(
      .SCREEN_WIDTH (SCREEN_W),
      .SCREEN_HEIGHT(SCREEN_H)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always #2 clock = ~clock;

   // Print one line per mismatch and count every one.
   task automatic flag_mismatch(input string msg);
      $display("mismatch: %s", msg);
      mismatch_count++;
   endtask

   // Apply one accepted transaction to the predictor state and list the byte writes it causes.
   function automatic void predict_writes(input req_type t, ref rsp_type w[$]);
      int         glyph_base;
      int         py;
      int         px;
      int         bcol;
      int         g;
      bit         all_rows;
      logic [7:0] bits;
      logic [7:0] m;
      rsp_type    wr;
      w.delete();
      if (t.operation == OP_LOAD) begin
         if (t.font_index < FONT_DEPTH) begin
            font_rows[t.font_index] = t.font_bits;
            row_loaded[t.font_index] = 1'b1;
            g = int'(t.font_index) / 8;
            all_rows = 1'b1;
            for (int r = 0; r < 8; r++) begin
               all_rows &= row_loaded[g * 8 + r];
            end
            if (all_rows && !glyph_ready[g]) begin
               glyph_ready[g] = 1'b1;
               ready_glyphs.push_back(g);
            end
         end
         return;
      end
      if (t.char_code < FIRST_CODE || t.char_code > FINAL_CODE) begin
         return;
      end
      glyph_base = (int'(t.char_code) - int'(FIRST_CODE)) * 8;
      for (int row = 0; row < 8; row++) begin
         py = int'(t.pos_y) + row;
         bits = font_rows[glyph_base + row];
         if (py >= SCREEN_H) begin
            continue;
         end
         for (int half = 0; half < 2; half++) begin
            bcol = (int'(t.pos_x) >> 3) + half;
            m = 8'h00;
            for (int c = 0; c < 8; c++) begin
               px = int'(t.pos_x) + c;
               if (bits[7 - c] && px < SCREEN_W && (px >> 3) == bcol) begin
                  m[7 - (px & 7)] = 1'b1;
               end
            end
            if (m != 8'h00 && w.size() < 16) begin
               wr.plane_addr = 16'((py * ROW_BYTES + bcol) & 16'hFFFF);
               wr.pixel_mask = m;
               wr.plane_values = t.colour;
               wr.last = 1'b0;
               w.push_back(wr);
            end
         end
      end
      if (w.size() > 0) begin
         w[w.size() - 1].last = 1'b1;
      end
   endfunction

   function automatic directed_step_type make_step(input logic op, input int x, input int y,
                                                   input int code, input int colour,
                                                   input int fidx, input int fbits,
                                                   input bit typed, input bit has_write,
                                                   input int offset, input int mask);
      directed_step_type s;
      s.item.operation = op;
      s.item.pos_x = 10'(x);
      s.item.pos_y = 10'(y);
      s.item.char_code = 8'(code);
      s.item.colour = 4'(colour);
      s.item.font_index = 10'(fidx);
      s.item.font_bits = 8'(fbits);
      s.typed = typed;
      s.has_write = has_write;
      s.write.plane_addr = 16'(offset);
      s.write.pixel_mask = 8'(mask);
      s.write.plane_values = 4'(colour);
      s.write.last = 1'b1;
      return s;
   endfunction

   function automatic req_type random_request();
      req_type t;
      t.operation = 1'($urandom_range(0, 1));
      t.pos_x = 10'($urandom_range(0, 1023));
      t.pos_y = 10'($urandom_range(0, 1023));
      t.char_code = 8'($urandom_range(0, 255));
      t.colour = 4'($urandom_range(0, 15));
      t.font_index = 10'($urandom_range(0, 1023));
      t.font_bits = 8'($urandom_range(0, 255));
      return t;
   endfunction

   // Font rows lean toward the empty and the full row so that clipping and straddles show up.
   function automatic logic [7:0] random_font_bits();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Drive one transaction, wait for it to be taken, then queue its expected writes.
   task automatic issue(input req_type t, input bit typed, input bit has_write,
                        input rsp_type write);
      rsp_type w [$];
      if (!calm && $urandom_range(0, 5) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 2)) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= t;
      do @(posedge clock); while (req_stall);
      predict_writes(t, w);
      if (typed) begin
         w.delete();
         if (has_write) begin
            w.push_back(write);
         end
      end
      foreach (w[i]) begin
         expected_writes.push_back(w[i]);
      end
   endtask

   // Result side stalls in short random bursts until the final stretch.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 3)) @(negedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   // Compare each accepted write with the oldest expected one.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_writes.size() == 0) begin
            flag_mismatch($sformatf("unexpected write at offset %0d", rsp_data.plane_addr));
         end else begin
            want = expected_writes.pop_front();
            if (rsp_data.plane_addr !== want.plane_addr) begin
               flag_mismatch($sformatf("plane_addr got %0d want %0d",
                                       rsp_data.plane_addr, want.plane_addr));
            end
            if (rsp_data.pixel_mask !== want.pixel_mask) begin
               flag_mismatch($sformatf("pixel_mask got %h want %h at offset %0d",
                                       rsp_data.pixel_mask, want.pixel_mask, want.plane_addr));
            end
            if (rsp_data.plane_values !== want.plane_values) begin
               flag_mismatch($sformatf("plane_values got %h want %h at offset %0d",
                                       rsp_data.plane_values, want.plane_values,
                                       want.plane_addr));
            end
            if (rsp_data.last !== want.last) begin
               flag_mismatch($sformatf("last got %b want %b at offset %0d",
                                       rsp_data.last, want.last, want.plane_addr));
            end
         end
      end
   end

   // Watchdog: end the run when no transaction moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      req_type t;
      rsp_type no_write;
      int      pick;
      int      g;
      int      x;
      int      y;

      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      no_write = '0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table. The space glyph gets a single pixel in its top-left corner first.
      steps.push_back(make_step(OP_LOAD, 0, 0, 0, 0, 0, 8'h80, 1, 0, 0, 0));
      for (int r = 1; r < 8; r++) begin
         steps.push_back(make_step(OP_LOAD, 0, 0, 0, 0, r, 8'h00, 1, 0, 0, 0));
      end
      // Highest store entry, then an index past the store that must be dropped.
      steps.push_back(make_step(OP_LOAD, 1023, 1023, 255, 15, 767, 8'hFF, 1, 0, 0, 0));
      steps.push_back(make_step(OP_LOAD, 0, 0, 0, 0, 1023, 8'hFF, 1, 0, 0, 0));
      // Corners of the screen, and cells that lie wholly past the right or bottom edge.
      steps.push_back(make_step(OP_DRAW, 0, 0, 8'h20, 15, 0, 0, 1, 1, 0, 8'h80));
      steps.push_back(make_step(OP_DRAW, 632, 472, 8'h20, 0, 0, 0, 1, 1,
                                472 * ROW_BYTES + 79, 8'h80));
      steps.push_back(make_step(OP_DRAW, 640, 0, 8'h20, 3, 0, 0, 1, 0, 0, 0));
      steps.push_back(make_step(OP_DRAW, 0, 480, 8'h20, 3, 0, 0, 1, 0, 0, 0));
      steps.push_back(make_step(OP_DRAW, 1023, 1023, 8'h20, 3, 1023, 255, 1, 0, 0, 0));
      // Codes outside the printable range draw nothing, then a draw shifted within its byte.
      steps.push_back(make_step(OP_DRAW, 0, 0, 8'h1F, 7, 0, 0, 1, 0, 0, 0));
      steps.push_back(make_step(OP_DRAW, 0, 0, 8'h80, 7, 0, 0, 1, 0, 0, 0));
      steps.push_back(make_step(OP_DRAW, 0, 0, 8'h00, 7, 0, 0, 1, 0, 0, 0));
      steps.push_back(make_step(OP_DRAW, 0, 0, 8'hFF, 7, 0, 0, 1, 0, 0, 0));
      steps.push_back(make_step(OP_DRAW, 3, 0, 8'h20, 5, 0, 0, 1, 1, 0, 8'h10));
      // A full top row then straddles a byte boundary and gets cut at the right edge.
      steps.push_back(make_step(OP_LOAD, 0, 0, 0, 0, 0, 8'hFF, 1, 0, 0, 0));
      steps.push_back(make_step(OP_DRAW, 5, 10, 8'h20, 10, 0, 0, 0, 0, 0, 0));
      steps.push_back(make_step(OP_DRAW, 636, 477, 8'h20, 9, 0, 0, 0, 0, 0, 0));

      foreach (steps[i]) begin
         issue(steps[i].item, steps[i].typed, steps[i].has_write, steps[i].write);
      end

      // Random part: mostly whole glyphs loaded then drawn, with stray loads and bad codes.
      while (counted_items < RANDOM_ITEMS) begin
         calm = (counted_items >= CALM_AFTER);
         pick = $urandom_range(0, 99);
         if (ready_glyphs.size() == 0 || pick < 25) begin
            g = (ready_glyphs.size() == 0) ? GLYPHS - 1 : $urandom_range(0, GLYPHS - 1);
            for (int r = 0; r < 8; r++) begin
               t = random_request();
               t.operation = OP_LOAD;
               t.font_index = 10'(g * 8 + r);
               t.font_bits = random_font_bits();
               issue(t, 0, 0, no_write);
               counted_items++;
            end
         end else if (pick < 35) begin
            t = random_request();
            t.operation = OP_LOAD;
            t.font_bits = random_font_bits();
            issue(t, 0, 0, no_write);
            if (t.font_index < FONT_DEPTH) begin
               counted_items++;
            end
         end else if (pick < 42) begin
            t = random_request();
            t.operation = OP_DRAW;
            t.char_code = $urandom_range(0, 1) ? 8'($urandom_range(0, 8'h1F))
                                               : 8'($urandom_range(8'h80, 8'hFF));
            issue(t, 0, 0, no_write);
         end else begin
            t = random_request();
            t.operation = OP_DRAW;
            g = ready_glyphs[$urandom_range(0, ready_glyphs.size() - 1)];
            t.char_code = 8'(g + int'(FIRST_CODE));
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               x = $urandom_range(0, SCREEN_W - 1);
               y = $urandom_range(0, SCREEN_H - 1);
            end else if (pick < 85) begin
               x = $urandom_range(SCREEN_W - 12, SCREEN_W + 3);
               y = $urandom_range(SCREEN_H - 10, SCREEN_H + 2);
            end else begin
               x = $urandom_range(0, 1023);
               y = $urandom_range(0, 1023);
            end
            t.pos_x = 10'(x);
            t.pos_y = 10'(y);
            issue(t, 0, 0, no_write);
            counted_items++;
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;

      // Drain the outstanding writes, then watch for strays.
      while (expected_writes.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
